// ===== design/wpl_pkg.sv =====
// Package for the warning priority list: sizes, action codes and the structs
// that pass between the list cells and the top level.
// Depends on nothing.
package wpl_pkg;

    localparam int MAX_IDS = 64;
    localparam int ID_W = 6;
    localparam int PRIO_W = 4;
    localparam int ACTION_W = 2;
    localparam int COUNT_W = 7;
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    typedef struct packed {
        logic              ins;
        logic              rel;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              take;
        logic              seen;
        logic              nxt_valid;
        logic [ID_W-1:0]   nxt_id;
    } cell_link_t;

endpackage

// ===== design/wpl_cell.sv =====
// One position of the sorted warning list: holds an entry and shifts it
// toward the tail on an insert or toward the head on a release.
// Depends on wpl_pkg.
module wpl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  wpl_pkg::cell_cmd_t  cmd,
    input  wpl_pkg::cell_link_t left,
    input  wpl_pkg::cell_link_t right,
    output wpl_pkg::cell_link_t link
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [wpl_pkg::ID_W-1:0]   id_reg;
    logic [wpl_pkg::ID_W-1:0]   id_next;
    logic [wpl_pkg::PRIO_W-1:0] prio_reg;
    logic [wpl_pkg::PRIO_W-1:0] prio_next;
    logic                       take;
    logic                       hit;

    assign take = !valid_reg || (cmd.prio <= prio_reg);
    assign hit = valid_reg && (id_reg == cmd.id);

    always_comb
    begin
        valid_next = valid_reg;
        id_next = id_reg;
        prio_next = prio_reg;
        if (cmd.ins)
        begin
            if (left.take)
            begin
                valid_next = left.valid;
                id_next = left.id;
                prio_next = left.prio;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                id_next = cmd.id;
                prio_next = cmd.prio;
            end
        end
        else if (cmd.rel && (left.seen || hit))
        begin
            valid_next = right.valid;
            id_next = right.id;
            prio_next = right.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        prio_reg <= prio_next;
    end

    assign link.valid = valid_reg;
    assign link.id = id_reg;
    assign link.prio = prio_reg;
    assign link.take = take;
    assign link.seen = left.seen || hit;
    assign link.nxt_valid = valid_next;
    assign link.nxt_id = id_next;

endmodule

// ===== design/warning_priority_list.sv =====
// Top level of the warning priority list: a row of list cells, the request
// decode and the registered result stage.
// Depends on wpl_pkg and wpl_cell.
//
// Requests enter on the s_axis channel and carry an action, a warning ID and
// its priority. A warning request inserts the ID in front of the first listed
// entry of equal or larger priority value unless the ID is already listed or
// the list is full; a release removes the ID if it is listed; a query changes
// nothing. Every accepted request produces exactly one result on the m_axis
// channel with the front ID, a valid flag and the entry count after the action.
// Each cell compares itself with the request in the same cycle and hands its
// entry to a neighbor, so a request is finished in the cycle it is accepted
// and its result shows in the next cycle. One request is accepted per cycle; the
// limit is the single result register, which is refilled in the cycle it is
// taken. When the receiver stalls, the result is held and s_axis_tready stays
// low until it is taken. Reset empties the list and drops any pending result;
// no clearing pass is needed, so requests are taken right after reset.
module warning_priority_list (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action [1:0], warning_id [7:2], priority_req [11:8], zeros above.
    input  logic [wpl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // front_id [5:0], front_valid [6], active_count [13:7], zeros above.
    output logic [wpl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic [wpl_pkg::ACTION_W-1:0] action;
    logic [wpl_pkg::ID_W-1:0]     warning_id;
    logic [wpl_pkg::PRIO_W-1:0]   priority_req;
    logic                         accept;
    logic                         found;
    logic                         full;
    logic                         in_range;
    logic                         do_ins;
    logic                         do_rel;
    wpl_pkg::cell_cmd_t           cmd;
    wpl_pkg::cell_link_t          lnk [wpl_pkg::MAX_IDS];
    wpl_pkg::cell_link_t          empty_link;
    logic [wpl_pkg::MAX_IDS-1:0]  valid_vec;

    logic [wpl_pkg::CNT_W-1:0]    count_reg;
    logic [wpl_pkg::CNT_W-1:0]    count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [wpl_pkg::ID_W-1:0]     front_id_reg;
    logic [wpl_pkg::ID_W-1:0]     front_id_next;
    logic                         front_valid_reg;
    logic                         front_valid_next;
    logic [wpl_pkg::COUNT_W-1:0]  out_count_reg;
    logic [wpl_pkg::COUNT_W-1:0]  out_count_next;

    assign action = s_axis_tdata[1:0];
    assign warning_id = s_axis_tdata[7:2];
    assign priority_req = s_axis_tdata[11:8];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign found = lnk[wpl_pkg::MAX_IDS-1].seen;
    assign full = lnk[wpl_pkg::MAX_IDS-1].valid;
    assign in_range = (int'(warning_id) < wpl_pkg::MAX_IDS);
    assign do_ins = accept && (action == wpl_pkg::ACT_REQUEST) && in_range && !found && !full;
    assign do_rel = accept && (action == wpl_pkg::ACT_RELEASE) && found;

    assign cmd.ins = do_ins;
    assign cmd.rel = do_rel;
    assign cmd.id = warning_id;
    assign cmd.prio = priority_req;

    assign empty_link = '0;

    genvar gi;
    generate
        for (gi = 0; gi < wpl_pkg::MAX_IDS; gi++)
        begin : g_cell
            wpl_pkg::cell_link_t left_link;
            wpl_pkg::cell_link_t right_link;
            if (gi == 0)
            begin : g_head
                assign left_link = empty_link;
            end
            else
            begin : g_body
                assign left_link = lnk[gi-1];
            end
            if (gi == wpl_pkg::MAX_IDS - 1)
            begin : g_tail
                assign right_link = empty_link;
            end
            else
            begin : g_inner
                assign right_link = lnk[gi+1];
            end
            wpl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (left_link),
                .right (right_link),
                .link  (lnk[gi])
            );
            assign valid_vec[gi] = lnk[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rel)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign front_valid_next = lnk[0].nxt_valid;
    assign front_id_next = lnk[0].nxt_valid ? lnk[0].nxt_id : '0;
    assign out_count_next = wpl_pkg::COUNT_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_id_reg <= front_id_next;
            front_valid_reg <= front_valid_next;
            out_count_reg <= out_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, out_count_reg, front_valid_reg, front_id_reg};

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_list_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells are not a prefix of the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not add one entry");

    a_front_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (front_valid_reg == (out_count_reg != '0)))
        else $error("front flag disagrees with reported count");

endmodule

// ===== dv/wpl_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the warning priority list. It keeps its own sorted list, predicts the status
// that follows every accepted request and compares each result against it.
// Depends on wpl_pkg.
module wpl_list_checker
    import wpl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [ID_W-1:0]    front_id;
        logic               front_valid;
        logic [COUNT_W-1:0] active_count;
    } list_status_t;

    logic [ID_W-1:0]   held_id[$];
    logic [PRIO_W-1:0] held_prio[$];
    list_status_t      status_queue[$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int find_held(input logic [ID_W-1:0] id);
        foreach (held_id[i])
        begin
            if (held_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic list_status_t apply_action(input logic [ACTION_W-1:0] action,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio);
        list_status_t st;
        int pos;
        int at;
        if (action == ACT_REQUEST && int'(id) < MAX_IDS && find_held(id) < 0
            && held_id.size() < MAX_IDS)
        begin
            // A new entry goes in front of the first one with an equal or larger value.
            pos = held_id.size();
            for (int i = 0; i < held_prio.size(); i++)
            begin
                if (prio <= held_prio[i])
                begin
                    pos = i;
                    break;
                end
            end
            held_id.insert(pos, id);
            held_prio.insert(pos, prio);
        end
        else if (action == ACT_RELEASE)
        begin
            at = find_held(id);
            if (at >= 0)
            begin
                held_id.delete(at);
                held_prio.delete(at);
            end
        end
        st.front_id = (held_id.size() != 0) ? held_id[0] : '0;
        st.front_valid = (held_id.size() != 0);
        st.active_count = COUNT_W'(held_id.size());
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        list_status_t want;
        list_status_t got;
        if (!rst_n)
        begin
            held_id.delete();
            held_prio.delete();
            status_queue.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                status_queue.insert(status_queue.size(), apply_action(
                    s_axis_tdata[ACTION_W-1:0],
                    s_axis_tdata[ACTION_W +: ID_W],
                    s_axis_tdata[ACTION_W+ID_W +: PRIO_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.front_id = m_axis_tdata[ID_W-1:0];
                got.front_valid = m_axis_tdata[ID_W];
                got.active_count = m_axis_tdata[ID_W+1 +: COUNT_W];
                if (status_queue.size() == 0)
                    report_mismatch("result with no request pending", 1, 0);
                else
                begin
                    want = status_queue.pop_front();
                    if (got.front_id !== want.front_id)
                        report_mismatch("front_id", got.front_id, want.front_id);
                    if (got.front_valid !== want.front_valid)
                        report_mismatch("front_valid", got.front_valid, want.front_valid);
                    if (got.active_count !== want.active_count)
                        report_mismatch("active_count", got.active_count, want.active_count);
                end
            end
        end
        outstanding = status_queue.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the warning priority list testbench: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on wpl_pkg, warning_priority_list and wpl_list_checker.
module tb_top;
    import wpl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    mismatches;
    int                    outstanding;
    int                    send_idle_pct = 30;
    int                    take_idle_pct = 58;

    warning_priority_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wpl_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({prio, id, action});
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic sweep_ids(input logic [ACTION_W-1:0] action);
        int order[MAX_IDS];
        int j;
        int tmp;
        foreach (order[i])
            order[i] = i;
        for (int i = MAX_IDS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_request(action, ID_W'(order[i]), PRIO_W'($urandom));
    endtask

    task automatic mixed_requests(input int count, input int request_pct);
        int pick;
        logic [ACTION_W-1:0] action;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < request_pct)
                action = ACT_REQUEST;
            else if (pick < 95)
                action = ACT_RELEASE;
            else
                action = $urandom_range(1) ? ACT_QUERY : ACT_SPARE;
            send_request(action, ID_W'($urandom), PRIO_W'($urandom));
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_request(ACT_QUERY, 6'd0, 4'd0);
        send_request(ACT_RELEASE, 6'd17, 4'd0);
        send_request(ACT_SPARE, 6'd63, 4'd15);
        send_request(ACT_REQUEST, 6'd63, 4'd15);
        send_request(ACT_REQUEST, 6'd0, 4'd0);
        send_request(ACT_REQUEST, 6'd10, 4'd0);
        send_request(ACT_REQUEST, 6'd20, 4'd15);
        send_request(ACT_REQUEST, 6'd63, 4'd0);
        send_request(ACT_REQUEST, 6'd33, 4'd7);
        send_request(ACT_RELEASE, 6'd10, 4'd3);
        send_request(ACT_RELEASE, 6'd63, 4'd0);
        send_request(ACT_RELEASE, 6'd33, 4'd0);
        send_request(ACT_RELEASE, 6'd63, 4'd0);
        send_request(ACT_SPARE, 6'd42, 4'd9);
        send_request(ACT_REQUEST, 6'd42, 4'd8);
        send_request(ACT_RELEASE, 6'd0, 4'd0);
        send_request(ACT_RELEASE, 6'd20, 4'd0);
        send_request(ACT_RELEASE, 6'd42, 4'd0);
        send_request(ACT_QUERY, 6'd42, 4'd15);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    take_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    take_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            sweep_ids(ACT_REQUEST);
            mixed_requests(50, 70);
            sweep_ids(ACT_RELEASE);
            mixed_requests(50, 50);
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("[warning_priority_list] OK");
        else
            $display("[warning_priority_list] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("[warning_priority_list] ERROR");
        $finish;
    end

endmodule

// ===== warning_priority_list.f =====
design/wpl_pkg.sv
design/wpl_cell.sv
design/warning_priority_list.sv
dv/wpl_list_checker.sv
dv/tb_top.sv
